// File: src/closure_confluence_checker_assert.svh
// Assertion macros used by the top-level design file.
`ifndef CLOSURE_CONFLUENCE_CHECKER_ASSERT_SVH
`define CLOSURE_CONFLUENCE_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/ccc_pkg.sv
package ccc_pkg;

    localparam int DEF_LABELS    = 32;
    localparam int DEF_MAX_PAIRS = 64;
    localparam int MAX_LABELS    = 64;
    localparam int FIELD_W       = 5;
    localparam int LABEL_EXT_W   = 7;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_EDGE  = 3'd1,
        CMD_INIT  = 3'd2,
        CMD_SPONT = 3'd3,
        CMD_PAIR  = 3'd4,
        CMD_CHECK = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_INIT  = 2'd1,
        KIND_SPONT = 2'd2
    } t_kind;

    typedef struct packed {
        logic clear;
        logic add_edge;
        logic mark_init;
        logic mark_spont;
        logic pivot;
        logic diag;
    } t_reach_ctrl;

    typedef struct packed {
        logic       found;
        logic [5:0] idx;
    } t_ffs;

    typedef struct packed {
        logic               hit;
        t_kind              kind;
        logic [FIELD_W-1:0] w1;
        logic [FIELD_W-1:0] w2;
    } t_pick;

    function automatic logic [2:0] lowest8(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic t_ffs lowest64(input logic [MAX_LABELS-1:0] v);
        logic [7:0] grp;
        logic [2:0] gi;
        logic [7:0] sub;
        t_ffs       res;
        for (int g = 0; g < 8; g++) begin
            grp[g] = |v[g*8 +: 8];
        end
        gi        = lowest8(grp);
        sub       = v[gi*8 +: 8];
        res.found = |grp;
        res.idx   = {gi, lowest8(sub)};
        return res;
    endfunction

endpackage

// File: src/ccc_ram.sv
module ccc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ccc_reach.sv
module ccc_reach #(
    parameter int LABELS = ccc_pkg::DEF_LABELS,
    localparam int LW = $clog2(LABELS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccc_pkg::t_reach_ctrl  i_ctrl,
    input  logic [LW-1:0]         i_src,
    input  logic [LW-1:0]         i_dst,
    input  logic [LW-1:0]         i_col_a,
    input  logic [LW-1:0]         i_col_b,
    output logic [LABELS-1:0]     o_init_a,
    output logic [LABELS-1:0]     o_init_b,
    output logic [LABELS-1:0]     o_spont_ab
);

    logic [LABELS-1:0] r_rows [LABELS];
    logic [LABELS-1:0] n_rows [LABELS];
    logic [LABELS-1:0] r_known, n_known;
    logic [LABELS-1:0] r_init, n_init;
    logic [LABELS-1:0] r_spont, n_spont;
    logic [LABELS-1:0] col_a, col_b;

    always_comb begin
        n_rows  = r_rows;
        n_known = r_known;
        n_init  = r_init;
        n_spont = r_spont;
        if (i_ctrl.clear) begin
            for (int i = 0; i < LABELS; i++) begin
                n_rows[i] = '0;
            end
            n_known = '0;
            n_init  = '0;
            n_spont = '0;
        end else begin
            if (i_ctrl.add_edge) begin
                n_rows[i_src][i_dst] = 1'b1;
                n_known[i_src]       = 1'b1;
                n_known[i_dst]       = 1'b1;
            end
            if (i_ctrl.mark_init) begin
                n_init[i_src] = 1'b1;
            end
            if (i_ctrl.mark_spont) begin
                n_spont[i_src] = 1'b1;
            end
            if (i_ctrl.pivot && r_known[i_src]) begin
                for (int i = 0; i < LABELS; i++) begin
                    if (r_rows[i][i_src]) begin
                        n_rows[i] = r_rows[i] | r_rows[i_src];
                    end
                end
            end
            if (i_ctrl.diag) begin
                for (int i = 0; i < LABELS; i++) begin
                    if (r_known[i]) begin
                        n_rows[i][i] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LABELS; i++) begin
                r_rows[i] <= '0;
            end
            r_known <= '0;
            r_init  <= '0;
            r_spont <= '0;
        end else begin
            r_rows  <= n_rows;
            r_known <= n_known;
            r_init  <= n_init;
            r_spont <= n_spont;
        end
    end

    always_comb begin
        for (int c = 0; c < LABELS; c++) begin
            col_a[c] = r_rows[c][i_col_a] & r_known[c] & r_known[i_col_a];
            col_b[c] = r_rows[c][i_col_b] & r_known[c] & r_known[i_col_b];
        end
    end

    assign o_init_a   = r_init & col_a;
    assign o_init_b   = r_init & col_b;
    assign o_spont_ab = r_spont & col_a & col_b;

endmodule

// File: src/ccc_pick.sv
module ccc_pick #(
    parameter int LABELS = ccc_pkg::DEF_LABELS
) (
    input  logic [LABELS-1:0] i_init_a,
    input  logic [LABELS-1:0] i_init_b,
    input  logic [LABELS-1:0] i_spont_ab,
    output ccc_pkg::t_pick    o_pick
);

    logic [ccc_pkg::MAX_LABELS-1:0] ext_ia, ext_ib, ext_sab;
    ccc_pkg::t_ffs ffs_ia, ffs_ib, ffs_sab;

    always_comb begin
        ext_ia                = '0;
        ext_ib                = '0;
        ext_sab               = '0;
        ext_ia[LABELS-1:0]    = i_init_a;
        ext_ib[LABELS-1:0]    = i_init_b;
        ext_sab[LABELS-1:0]   = i_spont_ab;
    end

    assign ffs_ia  = ccc_pkg::lowest64(ext_ia);
    assign ffs_ib  = ccc_pkg::lowest64(ext_ib);
    assign ffs_sab = ccc_pkg::lowest64(ext_sab);

    always_comb begin
        o_pick = '0;
        o_pick.kind = ccc_pkg::KIND_NONE;
        if (ffs_ia.found && ffs_ib.found) begin
            o_pick.hit  = 1'b1;
            o_pick.kind = ccc_pkg::KIND_INIT;
            o_pick.w1   = ffs_ia.idx[ccc_pkg::FIELD_W-1:0];
            o_pick.w2   = ffs_ib.idx[ccc_pkg::FIELD_W-1:0];
        end else if (ffs_sab.found) begin
            o_pick.hit  = 1'b1;
            o_pick.kind = ccc_pkg::KIND_SPONT;
            o_pick.w1   = ffs_sab.idx[ccc_pkg::FIELD_W-1:0];
        end
    end

endmodule

// File: src/closure_confluence_checker.sv
// Reachability checker for non-confluent label pairs.
// The input channel (i_in_valid, o_in_ready) takes one command item: clear, add edge,
// mark initial, mark spontaneous, add pair, or check. Load commands give no result.
// A check closes the edge relation with one pivot per cycle over all rows at once, sets
// the diagonal, then scans the stored pairs in load order through the pair memory, in a
// read, a column and a pick state per pair, and stops at the first pair with a witness.
// The result item appears on o_out_valid as the block returns to idle, when o_in_ready
// rises again. The block takes no new item while a check is in progress.
// Reset clears the relation, all marks, the pair count and the overflow flag; the
// pair memory itself is not cleared, since only stored entries are read.
// A result waits in the output register while i_out_ready is low; load commands
// are still taken meanwhile, and a finished check holds until the register frees.
module closure_confluence_checker #(
    parameter int LABELS    = ccc_pkg::DEF_LABELS,
    parameter int MAX_PAIRS = ccc_pkg::DEF_MAX_PAIRS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_cmd,
    input  logic [ccc_pkg::FIELD_W-1:0] i_first_label,
    input  logic [ccc_pkg::FIELD_W-1:0] i_second_label,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [1:0]                  o_kind,
    output logic [ccc_pkg::FIELD_W-1:0] o_pair_first,
    output logic [ccc_pkg::FIELD_W-1:0] o_pair_second,
    output logic [ccc_pkg::FIELD_W-1:0] o_witness_one,
    output logic [ccc_pkg::FIELD_W-1:0] o_witness_two,
    output logic                        o_pair_overflow
);

    `include "closure_confluence_checker_assert.svh"

    localparam int LW  = $clog2(LABELS);
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int AW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int LXW = ccc_pkg::LABEL_EXT_W;
    localparam int FW  = ccc_pkg::FIELD_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLOSE = 7'b0000010,
        S_DIAG  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_COL   = 7'b0010000,
        S_PICK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_pair_count, n_pair_count;
    logic                  r_dropped, n_dropped;
    logic                  r_out_valid, n_out_valid;

    logic [FW-1:0]         r_cur_a, r_cur_b;
    logic [LABELS-1:0]     r_m_ia, r_m_ib, r_m_sab;
    logic [LABELS-1:0]     m_ia, m_ib, m_sab;
    ccc_pkg::t_pick        pick;

    logic                  r_res_found, n_res_found;
    ccc_pkg::t_kind        r_res_kind, n_res_kind;
    logic [FW-1:0]         r_res_a, n_res_a;
    logic [FW-1:0]         r_res_b, n_res_b;
    logic [FW-1:0]         r_res_w1, n_res_w1;
    logic [FW-1:0]         r_res_w2, n_res_w2;

    logic                  r_o_found;
    ccc_pkg::t_kind        r_o_kind;
    logic [FW-1:0]         r_o_a, r_o_b, r_o_w1, r_o_w2;
    logic                  r_o_ovf;

    logic                  in_acc;
    logic                  out_free;
    logic                  load_out;
    logic                  a_ok, b_ok;
    ccc_pkg::t_cmd         cmd;
    ccc_pkg::t_reach_ctrl  ctrl;
    logic                  wr_en;
    logic                  rd_en;
    logic [2*FW-1:0]       rd_data;
    logic [LW-1:0]         src;

    assign cmd        = ccc_pkg::t_cmd'(i_cmd);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = (r_state == S_DONE) && out_free;
    assign a_ok       = LXW'(i_first_label) < LXW'(LABELS);
    assign b_ok       = LXW'(i_second_label) < LXW'(LABELS);
    assign src        = (r_state == S_CLOSE) ? r_k : LW'(i_first_label);
    assign rd_en      = (r_state == S_READ);
    assign wr_en      = in_acc && (cmd == ccc_pkg::CMD_PAIR) && a_ok && b_ok
                        && (r_pair_count != CW'(MAX_PAIRS));

    always_comb begin
        ctrl = '0;
        if (in_acc) begin
            case (cmd)
                ccc_pkg::CMD_CLEAR: ctrl.clear      = 1'b1;
                ccc_pkg::CMD_EDGE:  ctrl.add_edge   = a_ok && b_ok;
                ccc_pkg::CMD_INIT:  ctrl.mark_init  = a_ok;
                ccc_pkg::CMD_SPONT: ctrl.mark_spont = a_ok;
                default: ;
            endcase
        end
        ctrl.pivot = (r_state == S_CLOSE);
        ctrl.diag  = (r_state == S_DIAG);
    end

    ccc_reach #(
        .LABELS (LABELS)
    ) u_reach (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_src      (src),
        .i_dst      (LW'(i_second_label)),
        .i_col_a    (LW'(rd_data[2*FW-1:FW])),
        .i_col_b    (LW'(rd_data[FW-1:0])),
        .o_init_a   (m_ia),
        .o_init_b   (m_ib),
        .o_spont_ab (m_sab)
    );

    ccc_ram #(
        .WIDTH (2 * FW),
        .DEPTH (MAX_PAIRS)
    ) u_pair_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pair_count[AW-1:0]),
        .i_wr_data ({i_first_label, i_second_label}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    ccc_pick #(
        .LABELS (LABELS)
    ) u_pick (
        .i_init_a   (r_m_ia),
        .i_init_b   (r_m_ib),
        .i_spont_ab (r_m_sab),
        .o_pick     (pick)
    );

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_idx        = r_idx;
        n_pair_count = r_pair_count;
        n_dropped    = r_dropped;
        n_out_valid  = r_out_valid;
        n_res_found  = r_res_found;
        n_res_kind   = r_res_kind;
        n_res_a      = r_res_a;
        n_res_b      = r_res_b;
        n_res_w1     = r_res_w1;
        n_res_w2     = r_res_w2;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            case (cmd)
                ccc_pkg::CMD_CLEAR: begin
                    n_pair_count = '0;
                    n_dropped    = 1'b0;
                end
                ccc_pkg::CMD_PAIR: begin
                    if (wr_en) begin
                        n_pair_count = r_pair_count + CW'(1);
                    end else if (a_ok && b_ok) begin
                        n_dropped = 1'b1;
                    end
                end
                ccc_pkg::CMD_CHECK: begin
                    n_k     = '0;
                    n_state = S_CLOSE;
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: ;
            S_CLOSE: begin
                if (r_k == LW'(LABELS - 1)) begin
                    n_state = S_DIAG;
                end else begin
                    n_k = r_k + LW'(1);
                end
            end
            S_DIAG: begin
                n_idx       = '0;
                n_res_found = 1'b0;
                n_res_kind  = ccc_pkg::KIND_NONE;
                n_res_a     = '0;
                n_res_b     = '0;
                n_res_w1    = '0;
                n_res_w2    = '0;
                n_state     = (r_pair_count == '0) ? S_DONE : S_READ;
            end
            S_READ: n_state = S_COL;
            S_COL:  n_state = S_PICK;
            S_PICK: begin
                if (pick.hit) begin
                    n_res_found = 1'b1;
                    n_res_kind  = pick.kind;
                    n_res_a     = r_cur_a;
                    n_res_b     = r_cur_b;
                    n_res_w1    = pick.w1;
                    n_res_w2    = pick.w2;
                    n_state     = S_DONE;
                end else if (r_idx + CW'(1) == r_pair_count) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pair_count <= '0;
            r_dropped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pair_count <= n_pair_count;
            r_dropped    <= n_dropped;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_idx       <= n_idx;
        r_res_found <= n_res_found;
        r_res_kind  <= n_res_kind;
        r_res_a     <= n_res_a;
        r_res_b     <= n_res_b;
        r_res_w1    <= n_res_w1;
        r_res_w2    <= n_res_w2;
        if (r_state == S_COL) begin
            r_cur_a <= rd_data[2*FW-1:FW];
            r_cur_b <= rd_data[FW-1:0];
            r_m_ia  <= m_ia;
            r_m_ib  <= m_ib;
            r_m_sab <= m_sab;
        end
        if (load_out) begin
            r_o_found <= r_res_found;
            r_o_kind  <= r_res_kind;
            r_o_a     <= r_res_a;
            r_o_b     <= r_res_b;
            r_o_w1    <= r_res_w1;
            r_o_w2    <= r_res_w2;
            r_o_ovf   <= r_dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_o_found;
    assign o_kind          = r_o_kind;
    assign o_pair_first    = r_o_a;
    assign o_pair_second   = r_o_b;
    assign o_witness_one   = r_o_w1;
    assign o_witness_two   = r_o_w2;
    assign o_pair_overflow = r_o_ovf;

    `CCC_ASSERT_NEXT(a_check_starts_closure, i_clk, i_rst_n, in_acc && (cmd == ccc_pkg::CMD_CHECK), r_state == S_CLOSE)
    `CCC_ASSERT_IMPL(a_count_bounded, i_clk, i_rst_n, 1'b1, r_pair_count <= CW'(MAX_PAIRS))
    `CCC_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_DONE))
    `CCC_ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, r_state == S_READ, r_idx < r_pair_count)

endmodule
